/* rtl/assert_macros.svh */
// Assertion helpers. Each use expects clk and rst to be visible where it is expanded.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the trigger holds, the consequence holds in the following cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

/* rtl/lph_pkg.sv */
package lph_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 64;
  localparam int CNT_W = 11;
  localparam int SLOTS_DEF = 1024;

  localparam logic [3:0]       SIZE_LOG2_RST = 4'd10;
  localparam logic [CNT_W-1:0] COUNT_CAP     = 11'd1024;
  localparam logic [KEY_W-1:0] MARK_EMPTY    = 32'h0000_0000;
  localparam logic [KEY_W-1:0] MARK_TOMB     = 32'hFFFF_FFFF;

  localparam logic [1:0] CMD_GET = 2'd0;
  localparam logic [1:0] CMD_SET = 2'd1;
  localparam logic [1:0] CMD_DEL = 2'd2;

  typedef struct packed {
    logic [3:0] size_log2;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value_out;
    logic             table_full;
    logic             grow_wanted;
    logic [CNT_W-1:0] used_count;
    logic [CNT_W-1:0] deleted_count;
  } rsp_t;

  function automatic logic [KEY_W-1:0] mix(input logic [KEY_W-1:0] k);
    return k ^ (k >> 20) ^ (k >> 12) ^ (k >> 7) ^ (k >> 4);
  endfunction

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c < COUNT_CAP) ? c + CNT_W'(1) : COUNT_CAP;
  endfunction

endpackage

/* rtl/lph_chan_if.sv */
interface lph_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/lph_ram.sv */
module lph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/linear_probe_hash_table.sv */
// Channel  Dir  Payload                                     Transfer
// cfg      in   size_log2                                   cfg.valid & cfg.ready
// req      in   command, key, value_in                      req.valid & req.ready
// rsp      out  found, value_out, table_full, grow_wanted,  rsp.valid & rsp.ready
//               used_count, deleted_count
//
// After reset the key memory is cleared one slot per cycle, through all SLOTS slots.
// An item probes slots from its home slot on through the key memory read port, one per cycle;
// a reserved key skips the probe, and a full table is reported once every slot in use is probed.
// A finished result sits in the output register, so a new item is taken while it waits.
// A result waits in the sequencer only while the output register still holds an untaken one.
// The configuration register is written in any cycle.
`include "assert_macros.svh"

module linear_probe_hash_table #(
  parameter int SLOTS = lph_pkg::SLOTS_DEF
) (
  input logic         clk,
  input logic         rst,
  lph_chan_if.sink    cfg,
  lph_chan_if.sink    req,
  lph_chan_if.source  rsp
);

  import lph_pkg::*;

  localparam int ADDR_W = $clog2(SLOTS);
  localparam int CMP_W  = (ADDR_W + 1 > CNT_W) ? ADDR_W + 1 : CNT_W;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_CHECK, ST_DONE} state_t;

  state_t            state;
  logic [3:0]        size_log2;
  logic [3:0]        lg_eff;
  logic [ADDR_W-1:0] mask;
  logic [ADDR_W:0]   size_full;
  logic [ADDR_W:0]   grow_thresh;

  logic [1:0]        cmd;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  val;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] n;
  logic [ADDR_W-1:0] clr_addr;
  logic              found_r;
  logic              full_r;
  logic [VAL_W-1:0]  vout_r;
  logic [CNT_W-1:0]  used;
  logic [CNT_W-1:0]  deleted;

  logic [ADDR_W-1:0] home_addr;
  logic [ADDR_W-1:0] pos_inc;
  logic [ADDR_W-1:0] rd_addr;
  logic [KEY_W-1:0]  rd_key;
  logic [VAL_W-1:0]  rd_val;
  logic              key_empty;
  logic              key_hit;
  logic              stop;
  logic              is_set;
  logic              is_del;
  logic              reserved_in;
  logic              out_free;
  logic              key_wr_en;
  logic [ADDR_W-1:0] key_wr_addr;
  logic [KEY_W-1:0]  key_wr_data;
  logic              val_wr_en;

  assign lg_eff      = (size_log2 == 4'd0) ? 4'd1 : size_log2;
  assign mask        = ~({ADDR_W{1'b1}} << lg_eff);
  assign size_full   = {1'b0, mask} + (ADDR_W + 1)'(1);
  assign grow_thresh = (size_full >> 1) + (ADDR_W + 1)'(1);

  assign home_addr   = ADDR_W'(mix(req.data.key)) & mask;
  assign pos_inc     = (pos + ADDR_W'(1)) & mask;
  assign rd_addr     = (state == ST_CHECK) ? pos_inc : home_addr;

  assign key_empty   = (rd_key == MARK_EMPTY);
  assign key_hit     = (rd_key == key);
  assign stop        = key_empty || key_hit;
  assign is_set      = (cmd == CMD_SET);
  assign is_del      = (cmd == CMD_DEL);
  assign reserved_in = (req.data.key == MARK_EMPTY) || (req.data.key == MARK_TOMB);
  assign out_free    = !rsp.valid || rsp.ready;

  assign key_wr_en   = (state == ST_CLEAR) || ((state == ST_CHECK) && stop && (is_set || is_del));
  assign key_wr_addr = (state == ST_CLEAR) ? clr_addr : pos;
  assign key_wr_data = (state == ST_CLEAR) ? MARK_EMPTY : (is_del ? MARK_TOMB : key);
  assign val_wr_en   = (state == ST_CHECK) && stop && is_set;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE);

  lph_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (key_wr_addr),
    .wr_data (key_wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_key)
  );

  lph_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_val_ram (
    .clk     (clk),
    .wr_en   (val_wr_en),
    .wr_addr (pos),
    .wr_data (val),
    .rd_addr (rd_addr),
    .rd_data (rd_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      used      <= '0;
      deleted   <= '0;
      size_log2 <= SIZE_LOG2_RST;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        size_log2 <= cfg.data.size_log2;
      end
      if (rsp.valid && rsp.ready && (state != ST_DONE)) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            cmd     <= req.data.command;
            key     <= req.data.key;
            val     <= req.data.value_in;
            pos     <= home_addr;
            n       <= '0;
            found_r <= 1'b0;
            full_r  <= 1'b0;
            vout_r  <= '0;
            state   <= reserved_in ? ST_DONE : ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (stop) begin
            found_r <= key_hit;
            if (!is_set && !is_del && key_hit) begin
              vout_r <= rd_val;
            end
            if (is_del) begin
              deleted <= bump(deleted);
            end
            if ((is_set || is_del) && key_empty) begin
              used <= bump(used);
            end
            state <= ST_DONE;
          end else if (n == mask) begin
            full_r <= 1'b1;
            state  <= ST_DONE;
          end else begin
            pos <= pos_inc;
            n   <= n + ADDR_W'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            rsp.valid              <= 1'b1;
            rsp.data.found         <= found_r;
            rsp.data.value_out     <= vout_r;
            rsp.data.table_full    <= full_r;
            rsp.data.grow_wanted   <= CMP_W'(used) > CMP_W'(grow_thresh);
            rsp.data.used_count    <= used;
            rsp.data.deleted_count <= deleted;
            state                  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_probe_in_range, (state != ST_CHECK) || (((pos & ~mask) == '0) && (n <= mask)), "probe left the table in use")
  `ASSERT_ALWAYS(a_count_cap, (used <= COUNT_CAP) && (deleted <= COUNT_CAP), "slot counter passed its cap")
  `ASSERT_NEXT(a_one_item, req.valid && req.ready, !req.ready, "second item taken while one is in work")
  `ASSERT_ALWAYS(a_rsp_exclusive, !(rsp.valid && rsp.data.found && rsp.data.table_full), "result both found and full")

endmodule
